// ===== hdl/cmom_pkg.sv =====
package cmom_pkg;

    // accumulator and quotient width, wide enough for every power sum
    localparam int ACC_W   = 64;
    // width of a reported moment value
    localparam int VALUE_W = 57;
    localparam int KIND_W  = 2;

    // result kinds, in emission order
    localparam logic [KIND_W-1:0] KIND_MEAN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_M3   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_M4   = 2'd3;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DSTART,
        S_DWAIT,
        S_OUT,
        S_PASS,
        S_DRAIN
    } t_state;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/cmom_in_if.sv =====
interface cmom_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== hdl/cmom_out_if.sv =====
interface cmom_out_if
    import cmom_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         moment_kind;
    logic signed [VALUE_W-1:0] moment_value;
    logic                      too_many;
    logic                      last_result;

    modport source (output valid, output moment_kind, output moment_value,
                    output too_many, output last_result, input ready);
    modport sink   (input valid, input moment_kind, input moment_value,
                    input too_many, input last_result, output ready);
endinterface

// ===== hdl/cmom_ram.sv =====
module cmom_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cmom_div.sv =====
module cmom_div
    import cmom_pkg::*;
#(
    parameter int DIVISOR_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output t_div_rsp             o_rsp
);

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [STEP_W-1:0]    r_step;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // restoring step: remainder stays below the divisor, so trial < 2*divisor
    assign trial = {r_rem, r_quo[ACC_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = trial >= {1'b0, i_divisor};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ACC_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ACC_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hdl/central_moments_engine_top.sv =====
// Sample mean and central moments of a set of signed integer samples.
//
// Input channel i_in carries one sample per word; last_sample closes the set.
// Samples are taken one per cycle in the load state, written to an on-chip
// sample RAM and summed. Samples beyond MAX_SAMPLES are dropped and flagged.
// After the closing word the block emits four words on o_out: mean, variance,
// third and fourth central moment, fixed point with FRACTION_BITS fraction
// bits; too_many is the drop flag of the set, last_result marks the fourth.
//
// After the closing word the block runs four divisions in a shared
// bit-serial divider (mean first, then the three moment sums) and one pass
// over the N stored samples through a power pipeline fed by the RAM read
// port; input is not taken during computation.
// o_out has an output register: the block keeps working while a word waits,
// and the next set loads while the fourth moment is still held.
// Reset (synchronous, active low) empties the set and the output register;
// the sample RAM needs no clearing since only entries of the current set
// are read.
module central_moments_engine_top
    import cmom_pkg::*;
#(
    parameter int MAX_SAMPLES   = 256,
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmom_in_if.sink     i_in,
    cmom_out_if.source  o_out
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int MF_W   = SAMPLE_BITS + FRACTION_BITS + 1;
    localparam int DM_W   = SAMPLE_BITS + FRACTION_BITS;
    localparam int P2_W   = 2 * DM_W - FRACTION_BITS;
    localparam int P3_W   = P2_W + DM_W - FRACTION_BITS;
    localparam int P3L    = P3_W / 2;
    localparam int P3H    = P3_W - P3L;
    localparam int PP_W   = P3_W + DM_W;
    localparam int P4_W   = PP_W - FRACTION_BITS;
    localparam int VLD_N  = 6;

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [VLD_N-1:0]  r_vld;
    logic [MF_W-1:0]   r_mean;

    // handshake / strobes
    logic in_rdy, in_acc, out_load, rd_en, rd_last;

    // sample RAM
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // divider
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             div_start;
    logic [ACC_W-1:0] div_dividend;

    // power pipeline
    logic [MF_W-1:0]             xs;
    logic [MF_W:0]               dev;
    logic [MF_W:0]               dev_abs;
    logic [2*DM_W-1:0]           prod2;
    logic [P2_W+DM_W-1:0]        prod3;
    logic [PP_W-1:0]             pp_sum;
    logic [DM_W-1:0]             r_dm1, r_dm2, r_dm3;
    logic                        r_dn1, r_dn2, r_dn3;
    logic [P2_W-1:0]             r_p2;
    logic [P3_W-1:0]             r_p3;
    logic [P3H+DM_W-1:0]         r_pph;
    logic [P3L+DM_W-1:0]         r_ppl;
    logic [P4_W-1:0]             r_p4;

    // power sums
    logic [ACC_W-1:0] r_s2, r_s3p, r_s3n, r_s4;

    // results
    logic             sum_neg;
    logic [SUM_W-1:0] sum_abs;
    logic             s3_neg;
    logic [ACC_W-1:0] s3_mag;
    logic             res_neg;
    logic [ACC_W-1:0] res_val;

    // output register
    logic                      r_o_valid;
    logic [KIND_W-1:0]         r_o_kind;
    logic [VALUE_W-1:0]        r_o_value;
    logic                      r_o_too_many;
    logic                      r_o_last;

    assign in_acc  = i_in.valid && in_rdy;
    assign ram_we  = in_acc && (r_count < CNT_W'(MAX_SAMPLES));
    assign rd_last = CNT_W'(r_rd_idx) == (r_count - CNT_W'(1));

    // next state and strobes
    always_comb begin
        n_state   = r_state;
        in_rdy    = 1'b0;
        out_load  = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_LOAD: begin
                in_rdy = 1'b1;
                if (i_in.valid && i_in.last_sample) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    out_load = 1'b1;
                    if (r_kind == KIND_MEAN) begin
                        n_state = S_PASS;
                    end else if (r_kind == KIND_M4) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_PASS: begin
                rd_en = 1'b1;
                if (rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_vld == '0) begin
                    n_state = S_DSTART;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // set bookkeeping: count, sum, drop flag, result kind, read index, pass valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_ovf    <= 1'b0;
            r_kind   <= KIND_MEAN;
            r_rd_idx <= '0;
            r_vld    <= '0;
        end else begin
            r_vld <= {r_vld[VLD_N-2:0], rd_en};
            if (ram_we) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + {{(SUM_W-SAMPLE_BITS){i_in.sample[SAMPLE_BITS-1]}},
                                    i_in.sample};
            end else if (in_acc) begin
                r_ovf <= 1'b1;
            end
            if (out_load) begin
                r_kind <= r_kind + KIND_W'(1);
                if (r_kind == KIND_M4) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if (rd_en) begin
                r_rd_idx <= rd_last ? '0 : r_rd_idx + ADDR_W'(1);
            end
        end
    end

    cmom_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.sample),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // deviation from the mean, then its powers on magnitudes
    assign xs      = {{(FRACTION_BITS+1){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata}
                     << FRACTION_BITS;
    assign dev     = {xs[MF_W-1], xs} - {r_mean[MF_W-1], r_mean};
    assign dev_abs = dev[MF_W] ? (~dev + 1'b1) : dev;
    assign prod2   = r_dm1 * r_dm1;
    assign prod3   = r_p2 * r_dm2;
    assign pp_sum  = (PP_W'(r_pph) << P3L) + PP_W'(r_ppl);

    always_ff @(posedge i_clk) begin
        r_dm1 <= dev_abs[DM_W-1:0];
        r_dn1 <= dev[MF_W];
        r_p2  <= P2_W'(prod2 >> FRACTION_BITS);
        r_dm2 <= r_dm1;
        r_dn2 <= r_dn1;
        r_p3  <= P3_W'(prod3 >> FRACTION_BITS);
        r_dm3 <= r_dm2;
        r_dn3 <= r_dn2;
        // fourth power split in two partial products
        r_pph <= r_p3[P3_W-1:P3L] * r_dm3;
        r_ppl <= r_p3[P3L-1:0] * r_dm3;
        r_p4  <= P4_W'(pp_sum >> FRACTION_BITS);
    end

    // power sums, cleared as the pass starts
    always_ff @(posedge i_clk) begin
        if (out_load && (r_kind == KIND_MEAN)) begin
            r_s2  <= '0;
            r_s3p <= '0;
            r_s3n <= '0;
            r_s4  <= '0;
        end else begin
            if (r_vld[2]) begin
                r_s2 <= r_s2 + ACC_W'(r_p2);
            end
            if (r_vld[3]) begin
                if (r_dn3) begin
                    r_s3n <= r_s3n + ACC_W'(r_p3);
                end else begin
                    r_s3p <= r_s3p + ACC_W'(r_p3);
                end
            end
            if (r_vld[5]) begin
                r_s4 <= r_s4 + ACC_W'(r_p4);
            end
        end
    end

    // divider operands and signed results
    assign sum_neg = r_sum[SUM_W-1];
    assign sum_abs = sum_neg ? (~r_sum + 1'b1) : r_sum;
    assign s3_neg  = r_s3n > r_s3p;
    assign s3_mag  = s3_neg ? (r_s3n - r_s3p) : (r_s3p - r_s3n);

    always_comb begin
        case (r_kind)
            KIND_MEAN: div_dividend = ACC_W'(sum_abs) << FRACTION_BITS;
            KIND_VAR:  div_dividend = r_s2;
            KIND_M3:   div_dividend = s3_mag;
            KIND_M4:   div_dividend = r_s4;
            default:   div_dividend = '0;
        endcase
        case (r_kind)
            KIND_MEAN: res_neg = sum_neg;
            KIND_M3:   res_neg = s3_neg;
            default:   res_neg = 1'b0;
        endcase
    end

    assign div_req = {div_start, div_dividend};
    assign res_val = res_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

    cmom_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (r_count),
        .o_rsp     (div_rsp)
    );

    // mean kept for the deviation pass
    always_ff @(posedge i_clk) begin
        if (out_load && (r_kind == KIND_MEAN)) begin
            r_mean <= res_val[MF_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind     <= r_kind;
            r_o_value    <= res_val[VALUE_W-1:0];
            r_o_too_many <= r_ovf;
            r_o_last     <= r_kind == KIND_M4;
        end
    end

    assign i_in.ready         = in_rdy;
    assign o_out.valid        = r_o_valid;
    assign o_out.moment_kind  = r_o_kind;
    assign o_out.moment_value = r_o_value;
    assign o_out.too_many     = r_o_too_many;
    assign o_out.last_result  = r_o_last;

endmodule

// ===== hdl/cmom_chk.sv =====
module cmom_chk
    import cmom_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [KIND_W-1:0]  i_out_kind,
    input logic [VALUE_W-1:0] i_out_value
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_value))
        else $error("stalled output word changed");

    // input is no longer ready once the closing word is taken
    a_close_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken right after the closing word");

    // no input is taken while an earlier result of the set is still held
    a_no_input_mid_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_M4) |-> !i_in_ready)
        else $error("input ready before the fourth moment was produced");

endmodule

bind central_moments_engine_top cmom_chk u_cmom_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_sample),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.moment_kind),
    .i_out_value (o_out.moment_value)
);

// ===== bench/moments_checker.sv =====
`timescale 1ns / 100ps

module moments_checker
    import cmom_pkg::*;
#(
    parameter int MAX_SAMPLES   = 256,
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cmom_in_if   i_in_mon,
    cmom_out_if  i_out_mon,
    output int   o_words_due,
    output int   o_fail_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               too_many;
        logic               last_result;
    } t_moment_word;

    // samples of the set being loaded
    logic signed [SAMPLE_BITS-1:0] set_samples [MAX_SAMPLES];
    int   set_len;
    int   set_sum;
    logic set_dropped;

    // predicted result words, oldest first
    t_moment_word moments_due [$];

    // sign and magnitude to two's complement at the result width
    function automatic logic [VALUE_W-1:0] fixed_value(input logic neg, input logic [63:0] mag);
        logic [63:0] v;
        v = neg ? 64'd0 - mag : mag;
        return v[VALUE_W-1:0];
    endfunction

    function automatic void queue_moment(input logic [KIND_W-1:0] kind,
                                         input logic [VALUE_W-1:0] value);
        t_moment_word w;
        w.kind        = kind;
        w.value       = value;
        w.too_many    = set_dropped;
        w.last_result = (kind == KIND_M4);
        moments_due = {moments_due, w};
    endfunction

    // mean and central moments of the stored set, then start a new set
    function automatic void close_set();
        logic [63:0] n, mean_mag, dm, p2, p3, p4;
        logic [63:0] s2, s3_pos, s3_neg, s4, s3_mag;
        logic        mean_neg, s3_is_neg;
        longint      mean_fx, d;
        n        = 64'(set_len);
        mean_neg = set_sum < 0;
        mean_mag = mean_neg ? 64'(-set_sum) : 64'(set_sum);
        mean_mag = (n != 0) ? (mean_mag << FRACTION_BITS) / n : 64'd0;
        mean_fx  = mean_neg ? -longint'(mean_mag) : longint'(mean_mag);
        s2     = 64'd0;
        s3_pos = 64'd0;
        s3_neg = 64'd0;
        s4     = 64'd0;
        for (int i = 0; i < set_len; i++) begin
            d  = (longint'(set_samples[i]) <<< FRACTION_BITS) - mean_fx;
            dm = (d < 0) ? 64'(-d) : 64'(d);
            // each power truncated back to the fraction width
            p2 = (dm * dm) >> FRACTION_BITS;
            p3 = (p2 * dm) >> FRACTION_BITS;
            p4 = (p3 * dm) >> FRACTION_BITS;
            s2 += p2;
            if (d < 0) begin
                s3_neg += p3;
            end else begin
                s3_pos += p3;
            end
            s4 += p4;
        end
        s3_is_neg = s3_neg > s3_pos;
        s3_mag    = s3_is_neg ? s3_neg - s3_pos : s3_pos - s3_neg;

        queue_moment(KIND_MEAN, fixed_value(mean_neg, mean_mag));
        queue_moment(KIND_VAR,  fixed_value(1'b0, (n != 0) ? s2 / n : 64'd0));
        queue_moment(KIND_M3,   fixed_value(s3_is_neg, (n != 0) ? s3_mag / n : 64'd0));
        queue_moment(KIND_M4,   fixed_value(1'b0, (n != 0) ? s4 / n : 64'd0));

        set_len     = 0;
        set_sum     = 0;
        set_dropped = 1'b0;
    endfunction

    // compare one accepted result word with the oldest prediction
    function automatic void check_word();
        t_moment_word want;
        if (moments_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: unexpected word: kind %0d value %0d too_many %0b last %0b",
                         $time, i_out_mon.moment_kind, $signed(i_out_mon.moment_value),
                         i_out_mon.too_many, i_out_mon.last_result);
            return;
        end
        want = moments_due.pop_front();
        if (i_out_mon.moment_kind !== want.kind || i_out_mon.moment_value !== want.value ||
            i_out_mon.too_many !== want.too_many ||
            i_out_mon.last_result !== want.last_result) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: moment mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                         $time, want.kind, $signed(want.value), want.too_many,
                         want.last_result, i_out_mon.moment_kind,
                         $signed(i_out_mon.moment_value),
                         i_out_mon.too_many, i_out_mon.last_result);
        end
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_len     = 0;
            set_sum     = 0;
            set_dropped = 1'b0;
        end else begin
            // accepted sample word; past capacity it is not stored but raises the drop flag
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (set_len < MAX_SAMPLES) begin
                    set_samples[set_len] = i_in_mon.sample;
                    set_len++;
                    set_sum += int'(signed'(i_in_mon.sample));
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_in_mon.last_sample)
                    close_set();
            end
            // accepted result word
            if (i_out_mon.valid && i_out_mon.ready)
                check_word();
        end
        o_words_due = moments_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_SAMPLES   = 256;
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 1200;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_ITEMS   = 20;

    localparam logic [SAMPLE_BITS-1:0] S_MIN = 12'h800;
    localparam logic [SAMPLE_BITS-1:0] S_MAX = 12'h7FF;

    // traffic phases of the random part
    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH,
        PH_HOLD
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    t_phase      phase;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          items_sent;
    int          words_due;
    int          fail_count;
    int unsigned cycles;

    cmom_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    cmom_out_if out_if ();

    central_moments_engine_top #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    moments_checker #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) moment_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_if),
        .i_out_mon   (out_if),
        .o_words_due (words_due),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off in the pressure phase
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == PH_HOLD && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int unsigned style,
                                                           input int center);
        int v;
        case (style)
            0: v = int'($urandom_range(4095)) - 2048;
            1: v = $urandom_range(1) ? 2047 : -2048;
            default: v = center + int'($urandom_range(64)) - 32;
        endcase
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // one sample word, after a random gap
    task automatic send_word(input logic [SAMPLE_BITS-1:0] value, input logic closes);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample      <= value;
        in_if.last_sample <= closes;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        items_sent++;
    endtask

    // mostly short sets, now and then a longer one
    task automatic send_random_set();
        int unsigned len;
        int unsigned style;
        int          center;
        len    = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        style  = $urandom_range(2);
        center = int'($urandom_range(4095)) - 2048;
        for (int k = 1; k <= len; k++)
            send_word(pick_sample(style, center), k == len);
    endtask

    initial begin
        int phase_start;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.sample      <= '0;
        in_if.last_sample <= 1'b0;
        phase         = PH_FREE;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        items_sent    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-sample sets at the extremes and zero
        send_word(S_MIN, 1'b1);
        send_word(S_MAX, 1'b1);
        send_word(12'd0, 1'b1);
        // widest spread
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b1);
        // high outlier among lows: positive third moment
        repeat (3) send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b1);
        // low outlier among highs: negative third moment
        repeat (3) send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b1);
        // negative mean that does not divide evenly, rounds toward zero
        send_word(12'hFFF, 1'b0);
        send_word(12'hFFF, 1'b0);
        send_word(12'd0, 1'b1);
        // positive mean, mixed signs
        send_word(12'd5, 1'b0);
        send_word(12'hFFD, 1'b0);
        send_word(12'd7, 1'b1);
        // alternating bit patterns
        send_word(12'h555, 1'b0);
        send_word(12'hAAA, 1'b1);

        // random sets under each traffic pattern
        for (int p = PH_FREE; p <= PH_HOLD; p++) begin
            phase         = t_phase'(p);
            src_idle_pct  = (p == PH_SRC_IDLE) ? 51 : (p == PH_BOTH) ? 14 : 0;
            snk_stall_pct = (p == PH_SNK_STALL) ? 51 : (p == PH_BOTH) ? 14 : 0;
            phase_start   = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_set();
        end

        // drain
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
